@@ rtl/core/ulbr_pkg.sv @@
// ----------------------------------------------------------------------------
// ulbr_pkg
// Shared types and constants for the uart line buffer rings block.
// ----------------------------------------------------------------------------
package ulbr_pkg;

   localparam int BYTE_W   = 8;
   localparam int OP_W     = 3;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 6;
   localparam int COUNT_W  = 8;

   localparam logic [BYTE_W-1:0]  DELIM_RESET = 8'd13;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_RX_BYTE   = 3'd0,
      OP_TX_READY  = 3'd1,
      OP_SEND      = 3'd2,
      OP_READ_BYTE = 3'd3,
      OP_READ_LINE = 3'd4
   } op_type;

   // result item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE      = 3'd0,
      KIND_TX_BYTE   = 3'd1,
      KIND_READ_BYTE = 3'd2,
      KIND_LINE_BYTE = 3'd3,
      KIND_LINE_END  = 3'd4,
      KIND_ACK       = 3'd5
   } kind_type;

   // one result item as handed from the sequencer to the output register
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  data_out;
      logic               last;
      logic [LEN_W-1:0]   line_length;
      logic               truncated;
      logic               tx_interrupt_enable;
      logic [COUNT_W-1:0] lines_waiting;
   } rsp_item_type;

endpackage

@@ rtl/core/ulbr_req_if.sv @@
// ----------------------------------------------------------------------------
// ulbr_req_if
// Request channel: valid/ready handshake carrying one operation item.
// ----------------------------------------------------------------------------
interface ulbr_req_if import ulbr_pkg::*;;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [BYTE_W-1:0] data_in;
   logic              end_of_string;

   modport source (output valid, output opcode, output data_in, output end_of_string,
                   input ready);
   modport sink   (input valid, input opcode, input data_in, input end_of_string,
                   output ready);
endinterface

@@ rtl/core/ulbr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ulbr_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface ulbr_rsp_if import ulbr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [BYTE_W-1:0]  data_out;
   logic               last;
   logic [LEN_W-1:0]   line_length;
   logic               truncated;
   logic               tx_interrupt_enable;
   logic [COUNT_W-1:0] lines_waiting;

   modport source (output valid, output kind, output data_out, output last,
                   output line_length, output truncated, output tx_interrupt_enable,
                   output lines_waiting, input ready);
   modport sink   (input valid, input kind, input data_out, input last,
                   input line_length, input truncated, input tx_interrupt_enable,
                   input lines_waiting, output ready);
endinterface

@@ rtl/core/uart_line_buffer_rings_top.sv @@
// ----------------------------------------------------------------------------
// uart_line_buffer_rings_top
// Receive and transmit byte rings with line counting and line read-out.
//
//  channel   | direction | handshake          | carries
//  req_chan  | in        | valid/ready        | opcode, data_in, end_of_string
//  rsp_chan  | out       | valid/ready        | kind, data_out, last, line_length,
//            |           |                    | truncated, tx_interrupt_enable,
//            |           |                    | lines_waiting
//  csr_*     | in        | csr_we             | line_delimiter
//
// One item at a time: byte pushes and ring-empty answers go from dispatch to the
// result register, single byte pops first wait on one memory read. A read line
// scans the receive memory for the delimiter, one read per byte scanned, then
// reads each line byte or dropped byte in turn; the receive memory read port
// sets the pace.
// Reset is synchronous; pointers, line count and the irq flag clear, the ring
// memories hold their contents. A stalled result holds in the output register
// and the sequencer waits on it.
// ----------------------------------------------------------------------------
module uart_line_buffer_rings_top import ulbr_pkg::*; #(
   parameter int BUFFER_DEPTH = 256,
   parameter int MAX_LINE     = 63
) (
   input  logic              clock,
   input  logic              reset,
   ulbr_req_if.sink          req_chan,
   ulbr_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(BUFFER_DEPTH);

   logic              can_load;
   logic              emit_valid;
   rsp_item_type      emit_item;
   logic              rx_wr_en,   tx_wr_en;
   logic [PTR_W-1:0]  rx_wr_addr, tx_wr_addr;
   logic [PTR_W-1:0]  rx_rd_addr, tx_rd_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff,  rsp_item_in;

   ulbr_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_LINE     (MAX_LINE),
      .PTR_W        (PTR_W)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_opcode        (req_chan.opcode),
      .req_data_in       (req_chan.data_in),
      .req_end_of_string (req_chan.end_of_string),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .can_load          (can_load),
      .emit_valid        (emit_valid),
      .emit_item         (emit_item),
      .rx_wr_en          (rx_wr_en),
      .tx_wr_en          (tx_wr_en),
      .rx_wr_addr        (rx_wr_addr),
      .tx_wr_addr        (tx_wr_addr),
      .wr_data           (wr_data),
      .rx_rd_addr        (rx_rd_addr),
      .tx_rd_addr        (tx_rd_addr),
      .rx_rd_data        (rx_rd_data),
      .tx_rd_data        (tx_rd_data)
   );

   ulbr_ring_ram #(.DEPTH(BUFFER_DEPTH), .ADDR_W(PTR_W)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (wr_data),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   ulbr_ring_ram #(.DEPTH(BUFFER_DEPTH), .ADDR_W(PTR_W)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (wr_data),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // output register, refilled as the held item leaves
   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in  = rsp_item_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.kind                = rsp_item_ff.kind;
   assign rsp_chan.data_out            = rsp_item_ff.data_out;
   assign rsp_chan.last                = rsp_item_ff.last;
   assign rsp_chan.line_length         = rsp_item_ff.line_length;
   assign rsp_chan.truncated           = rsp_item_ff.truncated;
   assign rsp_chan.tx_interrupt_enable = rsp_item_ff.tx_interrupt_enable;
   assign rsp_chan.lines_waiting       = rsp_item_ff.lines_waiting;

endmodule

@@ rtl/core/ulbr_ring_ram.sv @@
// ----------------------------------------------------------------------------
// ulbr_ring_ram
// Byte-wide ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ulbr_ring_ram import ulbr_pkg::*; #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/ulbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ulbr_ctrl
// Sequencer for both rings: pointers, line count, transmit interrupt flag and
// the delimiter scan / line copy over the receive memory.
// ----------------------------------------------------------------------------
module ulbr_ctrl import ulbr_pkg::*; #(
   parameter int BUFFER_DEPTH = 256,
   parameter int MAX_LINE     = 63,
   parameter int PTR_W        = $clog2(BUFFER_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [BYTE_W-1:0]  req_data_in,
   input  logic               req_end_of_string,
   // delimiter register
   input  logic               csr_we,
   input  logic [BYTE_W-1:0]  csr_wdata,
   // result side
   input  logic               can_load,
   output logic               emit_valid,
   output rsp_item_type       emit_item,
   // memories
   output logic               rx_wr_en,
   output logic               tx_wr_en,
   output logic [PTR_W-1:0]   rx_wr_addr,
   output logic [PTR_W-1:0]   tx_wr_addr,
   output logic [BYTE_W-1:0]  wr_data,
   output logic [PTR_W-1:0]   rx_rd_addr,
   output logic [PTR_W-1:0]   tx_rd_addr,
   input  logic [BYTE_W-1:0]  rx_rd_data,
   input  logic [BYTE_W-1:0]  tx_rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_WAIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_LN_RD,
      ST_LN_DATA,
      ST_LN_END,
      ST_ONE
   } state_type;

   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE);

   state_type          state_ff,      state_in;
   logic [PTR_W-1:0]   rx_wr_ptr_ff,  rx_wr_ptr_in;
   logic [PTR_W-1:0]   rx_rd_ptr_ff,  rx_rd_ptr_in;
   logic [PTR_W-1:0]   tx_wr_ptr_ff,  tx_wr_ptr_in;
   logic [PTR_W-1:0]   tx_rd_ptr_ff,  tx_rd_ptr_in;
   logic [PTR_W-1:0]   scan_ptr_ff,   scan_ptr_in;
   logic [COUNT_W-1:0] count_ff,      count_in;
   logic               irq_ff,        irq_in;
   logic [BYTE_W-1:0]  delim_ff,      delim_in;
   logic [OP_W-1:0]    op_ff,         op_in;
   logic [BYTE_W-1:0]  data_ff,       data_in;
   logic               eos_ff,        eos_in;
   logic [KIND_W-1:0]  pend_kind_ff,  pend_kind_in;
   logic [BYTE_W-1:0]  pend_data_ff,  pend_data_in;
   logic [LEN_W-1:0]   len_ff,        len_in;
   logic               trunc_ff,      trunc_in;

   function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // fixed memory hookups
   assign req_ready  = (state_ff == ST_IDLE);
   assign rx_wr_addr = rx_wr_ptr_ff;
   assign tx_wr_addr = tx_wr_ptr_ff;
   assign wr_data    = data_ff;
   assign tx_rd_addr = tx_rd_ptr_ff;
   assign rx_rd_addr = (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_CHK) ?
                       scan_ptr_ff : rx_rd_ptr_ff;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      scan_ptr_in  = scan_ptr_ff;
      count_in     = count_ff;
      irq_in       = irq_ff;
      delim_in     = csr_we ? csr_wdata : delim_ff;
      op_in        = op_ff;
      data_in      = data_ff;
      eos_in       = eos_ff;
      pend_kind_in = pend_kind_ff;
      pend_data_in = pend_data_ff;
      len_in       = len_ff;
      trunc_in     = trunc_ff;
      rx_wr_en     = 1'b0;
      tx_wr_en     = 1'b0;
      emit_valid   = 1'b0;

      emit_item.kind                = pend_kind_ff;
      emit_item.data_out            = pend_data_ff;
      emit_item.last                = 1'b1;
      emit_item.line_length         = '0;
      emit_item.truncated           = 1'b0;
      emit_item.tx_interrupt_enable = irq_ff;
      emit_item.lines_waiting       = count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               data_in  = req_data_in;
               eos_in   = req_end_of_string;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            pend_data_in = '0;
            pend_kind_in = KIND_NONE;
            state_in     = ST_ONE;
            case (op_ff)
               OP_RX_BYTE: begin
                  rx_wr_en     = 1'b1;
                  tx_wr_en     = 1'b1;
                  rx_wr_ptr_in = adv(rx_wr_ptr_ff);
                  tx_wr_ptr_in = adv(tx_wr_ptr_ff);
                  irq_in       = 1'b1;
                  pend_kind_in = KIND_ACK;
                  if (data_ff == delim_ff && count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_TX_READY: begin
                  if (tx_rd_ptr_ff == tx_wr_ptr_ff) begin
                     irq_in = 1'b0;
                  end else begin
                     pend_kind_in = KIND_TX_BYTE;
                     state_in     = ST_RD_WAIT;
                  end
               end
               OP_SEND: begin
                  tx_wr_en     = 1'b1;
                  tx_wr_ptr_in = adv(tx_wr_ptr_ff);
                  pend_kind_in = KIND_ACK;
                  if (eos_ff) begin
                     irq_in = 1'b1;
                  end
               end
               OP_READ_BYTE: begin
                  if (rx_rd_ptr_ff != rx_wr_ptr_ff) begin
                     pend_kind_in = KIND_READ_BYTE;
                     state_in     = ST_RD_WAIT;
                  end
               end
               OP_READ_LINE: begin
                  if (count_ff != '0) begin
                     scan_ptr_in = rx_rd_ptr_ff;
                     state_in    = ST_SCAN_RD;
                  end
               end
               default: begin
                  pend_kind_in = KIND_NONE;
               end
            endcase
         end

         // memory data for the single byte pop is in now
         ST_RD_WAIT: begin
            if (pend_kind_ff == KIND_TX_BYTE) begin
               pend_data_in = tx_rd_data;
               tx_rd_ptr_in = adv(tx_rd_ptr_ff);
            end else begin
               pend_data_in = rx_rd_data;
               rx_rd_ptr_in = adv(rx_rd_ptr_ff);
            end
            state_in = ST_ONE;
         end

         // delimiter search between read and write pointers
         ST_SCAN_RD: begin
            if (scan_ptr_ff == rx_wr_ptr_ff) begin
               pend_kind_in = KIND_NONE;
               state_in     = ST_ONE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end

         ST_SCAN_CHK: begin
            if (rx_rd_data == delim_ff) begin
               len_in   = '0;
               trunc_in = 1'b0;
               state_in = ST_LN_RD;
            end else begin
               scan_ptr_in = adv(scan_ptr_ff);
               state_in    = ST_SCAN_RD;
            end
         end

         // line copy, scan pointer marks the delimiter
         ST_LN_RD: begin
            state_in = (rx_rd_ptr_ff == scan_ptr_ff) ? ST_LN_END : ST_LN_DATA;
         end

         ST_LN_DATA: begin
            if (len_ff == LEN_LIMIT) begin
               trunc_in     = 1'b1;
               rx_rd_ptr_in = adv(rx_rd_ptr_ff);
               state_in     = ST_LN_RD;
            end else if (can_load) begin
               emit_valid         = 1'b1;
               emit_item.kind     = KIND_LINE_BYTE;
               emit_item.data_out = rx_rd_data;
               emit_item.last     = 1'b0;
               len_in             = len_ff + 1'b1;
               rx_rd_ptr_in       = adv(rx_rd_ptr_ff);
               state_in           = ST_LN_RD;
            end
         end

         ST_LN_END: begin
            if (can_load) begin
               emit_valid              = 1'b1;
               emit_item.kind          = KIND_LINE_END;
               emit_item.data_out      = '0;
               emit_item.line_length   = len_ff;
               emit_item.truncated     = trunc_ff;
               emit_item.lines_waiting = count_ff - 1'b1;
               count_in                = count_ff - 1'b1;
               rx_rd_ptr_in            = adv(rx_rd_ptr_ff);
               state_in                = ST_IDLE;
            end
         end

         ST_ONE: begin
            if (can_load) begin
               emit_valid = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         count_ff     <= '0;
         irq_ff       <= 1'b0;
         delim_ff     <= DELIM_RESET;
      end else begin
         state_ff     <= state_in;
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         count_ff     <= count_in;
         irq_ff       <= irq_in;
         delim_ff     <= delim_in;
      end
      scan_ptr_ff  <= scan_ptr_in;
      op_ff        <= op_in;
      data_ff      <= data_in;
      eos_ff       <= eos_in;
      pend_kind_ff <= pend_kind_in;
      pend_data_ff <= pend_data_in;
      len_ff       <= len_in;
      trunc_ff     <= trunc_in;
   end

endmodule

@@ rtl/core/ulbr_checker.sv @@
// ----------------------------------------------------------------------------
// ulbr_checker
// Port-level checks on request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module ulbr_checker import ulbr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [KIND_W-1:0]  rsp_kind,
   input logic               rsp_last,
   input logic [LEN_W-1:0]   rsp_line_length,
   input logic [BYTE_W-1:0]  rsp_data_out
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_kind))
      else $error("result item changed while stalled");

   // one item in work at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted back to back");

   // only line bytes leave last low
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_LINE_BYTE)))
      else $error("last flag does not match item kind");

   // length shows only on a line end
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_LINE_END |-> rsp_line_length == '0)
      else $error("line length outside line end");

   // no undefined kind codes
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_NONE || rsp_kind == KIND_TX_BYTE ||
                     rsp_kind == KIND_READ_BYTE || rsp_kind == KIND_LINE_BYTE ||
                     rsp_kind == KIND_LINE_END || rsp_kind == KIND_ACK))
      else $error("undefined result kind");

endmodule

bind uart_line_buffer_rings_top ulbr_checker u_ulbr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_last        (rsp_chan.last),
   .rsp_line_length (rsp_chan.line_length),
   .rsp_data_out    (rsp_chan.data_out)
);

@@ sim/tb_uart_line_buffer_rings_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_line_buffer_rings_top
// Self-checking bench for the uart receive/transmit line rings. Items are sent
// over the request channel and mirrored into an internal model of both rings,
// the line counter and the irq flag. Every result item is compared field by
// field, in order, with the model's answers. Both sides idle in random bursts,
// the delimiter register is swept over several values, the extremes included.
// ----------------------------------------------------------------------------
module tb_uart_line_buffer_rings_top;
   import ulbr_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int LINE_MAX    = 63;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 20;
   localparam int IDLE_CYCLES = 4;
   localparam int HOLD_CYCLES = 300;

   // opcodes the block does not use
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [BYTE_W-1:0] csr_wdata;

   ulbr_req_if req_chan();
   ulbr_rsp_if rsp_chan();

   uart_line_buffer_rings_top #(
      .BUFFER_DEPTH(RING_DEPTH),
      .MAX_LINE    (LINE_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   // model of the rings, line counter and irq flag
   logic [BYTE_W-1:0]  rx_ring_mem [RING_DEPTH];
   logic [BYTE_W-1:0]  tx_ring_mem [RING_DEPTH];
   logic [IDX_W-1:0]   rx_wr_idx = '0;
   logic [IDX_W-1:0]   rx_rd_idx = '0;
   logic [IDX_W-1:0]   tx_wr_idx = '0;
   logic [IDX_W-1:0]   tx_rd_idx = '0;
   logic [COUNT_W-1:0] lines_held;
   logic               tx_irq;
   logic [BYTE_W-1:0]  line_delim;

   // result items still owed by the block, oldest first
   rsp_item_type ring_answers[$];

   int fail_count = 0;
   int items_sent = 0;
   int long_hold  = 0;
   int rsp_stall  = 0;
   bit idling_on  = 1'b1;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [IDX_W-1:0] ring_next(logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   // queue one answer carrying the current irq flag and line count
   function automatic void post_answer(kind_type k, logic [BYTE_W-1:0] d, logic lst,
                                       logic [LEN_W-1:0] len, logic trunc);
      rsp_item_type a;
      a.kind                = k;
      a.data_out            = d;
      a.last                = lst;
      a.line_length         = len;
      a.truncated           = trunc;
      a.tx_interrupt_enable = tx_irq;
      a.lines_waiting       = lines_held;
      ring_answers.push_back(a);
   endfunction

   // advance the ring model by one accepted item and queue its answers
   function automatic void apply_ring_op(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                         logic eos);
      logic [IDX_W-1:0] scan;
      int total;
      int emitted;
      bit found;
      case (op)
         OP_RX_BYTE: begin
            if (data == line_delim && lines_held < COUNT_MAX) lines_held++;
            rx_ring_mem[rx_wr_idx] = data;
            rx_wr_idx = ring_next(rx_wr_idx);
            tx_ring_mem[tx_wr_idx] = data;
            tx_wr_idx = ring_next(tx_wr_idx);
            tx_irq = 1'b1;
            post_answer(KIND_ACK, 0, 1'b1, 0, 1'b0);
         end
         OP_TX_READY: begin
            if (tx_rd_idx == tx_wr_idx) begin
               tx_irq = 1'b0;
               post_answer(KIND_NONE, 0, 1'b1, 0, 1'b0);
            end else begin
               post_answer(KIND_TX_BYTE, tx_ring_mem[tx_rd_idx], 1'b1, 0, 1'b0);
               tx_rd_idx = ring_next(tx_rd_idx);
            end
         end
         OP_SEND: begin
            tx_ring_mem[tx_wr_idx] = data;
            tx_wr_idx = ring_next(tx_wr_idx);
            if (eos) tx_irq = 1'b1;
            post_answer(KIND_ACK, 0, 1'b1, 0, 1'b0);
         end
         OP_READ_BYTE: begin
            if (rx_rd_idx == rx_wr_idx) begin
               post_answer(KIND_NONE, 0, 1'b1, 0, 1'b0);
            end else begin
               post_answer(KIND_READ_BYTE, rx_ring_mem[rx_rd_idx], 1'b1, 0, 1'b0);
               rx_rd_idx = ring_next(rx_rd_idx);
            end
         end
         OP_READ_LINE: begin
            // look for the delimiter between the read and write pointers
            found = 1'b0;
            scan  = rx_rd_idx;
            if (lines_held != 0) begin
               while (!found && scan != rx_wr_idx) begin
                  if (rx_ring_mem[scan] == line_delim) found = 1'b1;
                  else scan = ring_next(scan);
               end
            end
            if (!found) begin
               post_answer(KIND_NONE, 0, 1'b1, 0, 1'b0);
            end else begin
               // bytes past the line limit are consumed but not emitted
               total   = 0;
               emitted = 0;
               while (rx_rd_idx != scan) begin
                  if (total < LINE_MAX) begin
                     post_answer(KIND_LINE_BYTE, rx_ring_mem[rx_rd_idx], 1'b0, 0, 1'b0);
                     emitted++;
                  end
                  total++;
                  rx_rd_idx = ring_next(rx_rd_idx);
               end
               rx_rd_idx  = ring_next(rx_rd_idx);
               lines_held = lines_held - 1'b1;
               post_answer(KIND_LINE_END, 0, 1'b1, LEN_W'(emitted), total > LINE_MAX);
            end
         end
         default: post_answer(KIND_NONE, 0, 1'b1, 0, 1'b0);
      endcase
   endfunction

   // offer one item, maybe after a short gap, and wait for its handshake
   task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic eos);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.data_in       <= data;
      req_chan.end_of_string <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_ring_op(op, data, eos);
      items_sent++;
   endtask

   // stop offering and wait until every owed result has come back
   task automatic settle_block();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (ring_answers.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_delimiter(logic [BYTE_W-1:0] value);
      settle_block();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we     <= 1'b0;
      line_delim  = value;
   endtask

   // received bytes that avoid the delimiter, then the delimiter
   task automatic send_line(int len);
      logic [BYTE_W-1:0] b;
      for (int k = 0; k < len; k++) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == line_delim) b = ~b;
         send_item(OP_RX_BYTE, b, 1'($urandom_range(0, 1)));
      end
      send_item(OP_RX_BYTE, line_delim, 1'($urandom_range(0, 1)));
   endtask

   // whole lines and their reads, single ops and raw noise
   task automatic random_ring_op();
      int                pick;
      int                len;
      logic [BYTE_W-1:0] b;
      pick = $urandom_range(0, 99);
      b    = BYTE_W'($urandom_range(0, 255));
      if (pick < 30) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
         send_line(len);
      end else if (pick < 45) begin
         send_item(OP_READ_LINE, b, 1'($urandom_range(0, 1)));
      end else if (pick < 60) begin
         send_item(OP_TX_READY, b, 1'($urandom_range(0, 1)));
      end else if (pick < 72) begin
         send_item(OP_SEND, b, $urandom_range(0, 2) == 0);
      end else if (pick < 82) begin
         send_item(OP_READ_BYTE, b, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
         if ($urandom_range(0, 3) == 0) b = line_delim;
         send_item(OP_RX_BYTE, b, 1'($urandom_range(0, 1)));
      end else begin
         send_item(OP_W'($urandom_range(int'(OP_RX_BYTE), int'(OP_SPARE_LAST))), b,
                   1'($urandom_range(0, 1)));
      end
   endtask

   // empty rings, spare opcodes, echo, a stale line count and an empty line
   task automatic test_directed_basics();
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      send_item(OP_TX_READY, 8'hFF, 1'b1);
      send_item(OP_READ_BYTE, 8'h00, 1'b0);
      send_item(OP_SPARE_FIRST, 8'hFF, 1'b1);
      send_item(OP_SPARE_LAST, 8'h00, 1'b0);
      send_item(OP_SEND, 8'h00, 1'b0);
      send_item(OP_SEND, 8'hFF, 1'b1);
      repeat (3) send_item(OP_TX_READY, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, 8'h68, 1'b0);
      send_item(OP_RX_BYTE, 8'h69, 1'b1);
      send_item(OP_RX_BYTE, 8'hFF, 1'b0);
      send_item(OP_RX_BYTE, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, DELIM_RESET, 1'b0);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      // popping the delimiter byte by byte leaves the count behind
      send_item(OP_RX_BYTE, 8'h61, 1'b0);
      send_item(OP_RX_BYTE, DELIM_RESET, 1'b0);
      repeat (2) send_item(OP_READ_BYTE, 8'h00, 1'b0);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      send_item(OP_RX_BYTE, DELIM_RESET, 1'b0);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
   endtask

   // lines right at and just over the length limit
   task automatic test_long_lines();
      send_line(LINE_MAX);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      send_line(LINE_MAX + 1);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
   endtask

   task automatic test_delimiter_extremes();
      write_delimiter(8'h00);
      send_line(3);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      write_delimiter(8'hFF);
      send_line(2);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      // a counted line whose delimiter no longer matches the register
      send_item(OP_RX_BYTE, 8'h41, 1'b0);
      send_item(OP_RX_BYTE, 8'h42, 1'b0);
      send_item(OP_RX_BYTE, 8'hFF, 1'b0);
      write_delimiter(8'h00);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      repeat (3) send_item(OP_READ_BYTE, 8'h00, 1'b0);
      write_delimiter(DELIM_RESET);
   endtask

   // random traffic in phases, each under its own delimiter
   task automatic test_random_traffic();
      int                stop_at;
      int                phase_end;
      int                phase;
      logic [BYTE_W-1:0] d;
      stop_at = items_sent + 60;
      phase   = 0;
      while (items_sent < stop_at) begin
         case (phase % 4)
            0:       d = BYTE_W'($urandom_range(0, 255));
            1:       d = 8'h00;
            2:       d = 8'hFF;
            default: d = DELIM_RESET;
         endcase
         write_delimiter(d);
         phase_end = items_sent + 15;
         while (items_sent < phase_end) random_ring_op();
         phase++;
      end
   endtask

   // receiver holds off while items keep coming, then the sender drains
   task automatic test_backpressure();
      long_hold = HOLD_CYCLES;
      send_line(10);
      send_item(OP_READ_LINE, 8'h00, 1'b0);
      repeat (4) send_item(OP_TX_READY, 8'h00, 1'b0);
      send_item(OP_READ_BYTE, 8'h00, 1'b0);
      settle_block();
   endtask

   task automatic test_quiet_tail();
      idling_on = 1'b0;
      repeat (8) random_ring_op();
   endtask

   task automatic check_field(string field, logic [BYTE_W-1:0] want,
                              logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // result side ready, with random stalls and the long hold-off
   initial begin : rsp_ready_driver
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            long_hold--;
         end else if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_stall       = $urandom_range(1, 6) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // compare each result item with the oldest owed answer
   initial begin : rsp_checker
      rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (ring_answers.size() == 0) begin
               $display("%0t: result item with none owed, expected nothing, actual kind %0d",
                        $time, rsp_chan.kind);
               fail_count++;
            end else begin
               want = ring_answers.pop_front();
               check_field("kind", BYTE_W'(want.kind), BYTE_W'(rsp_chan.kind));
               check_field("data_out", want.data_out, rsp_chan.data_out);
               check_field("last", BYTE_W'(want.last), BYTE_W'(rsp_chan.last));
               check_field("line_length", BYTE_W'(want.line_length),
                           BYTE_W'(rsp_chan.line_length));
               check_field("truncated", BYTE_W'(want.truncated),
                           BYTE_W'(rsp_chan.truncated));
               check_field("tx_interrupt_enable", BYTE_W'(want.tx_interrupt_enable),
                           BYTE_W'(rsp_chan.tx_interrupt_enable));
               check_field("lines_waiting", want.lines_waiting, rsp_chan.lines_waiting);
            end
         end
      end
   end

   initial begin : run_limit
      #50ms;
      $display("FAILURE");
      $finish;
   end

   // test sequence
   initial begin : main_sequence
      int guard;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = DELIM_RESET;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = OP_RX_BYTE;
      req_chan.data_in       = '0;
      req_chan.end_of_string = 1'b0;
      line_delim             = DELIM_RESET;
      lines_held             = '0;
      tx_irq                 = 1'b0;
      foreach (rx_ring_mem[i]) rx_ring_mem[i] = '0;
      foreach (tx_ring_mem[i]) tx_ring_mem[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_long_lines();
      test_delimiter_extremes();
      test_random_traffic();
      test_backpressure();
      test_quiet_tail();

      // drain what is still owed, bounded
      @(negedge clock);
      req_chan.valid <= 1'b0;
      guard = 0;
      while (ring_answers.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (ring_answers.size() != 0) begin
         $display("%0t: results missing at end, expected %0d more, actual 0", $time,
                  ring_answers.size());
         fail_count++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
